// ===== rtl/assert_macros.svh =====
// assertion macros included by the identifier scanner top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/cis_pkg.sv =====
// types and constants of the identifier scanner
package cis_pkg;

    localparam int KW_SLOTS = 32;

    typedef enum logic [3:0] {
        M_NORMAL, M_SLASH, M_COMMENT, M_COMMENT_STAR, M_STRING, M_CHAR_FIRST,
        M_CHAR_ESC, M_CHAR_CLOSE, M_PREPROC, M_PREPROC_CONT, M_NUMBER, M_IDENT
    } scan_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_KW_READ, ST_MATCH, ST_KW_WRITE, ST_EMIT_RD, ST_EMIT, ST_END, ST_ERR
    } ctl_state_t;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_COUNT = 2'd1;
    localparam logic [1:0] KIND_END = 2'd2;
    localparam logic [1:0] KIND_TOO_LONG = 2'd3;

    localparam logic [7:0] BYTE_EOT = 8'hFF;
    localparam logic [7:0] BYTE_LF = 8'h0A;
    localparam logic [7:0] BYTE_PAREN = 8'h28;
    localparam logic [7:0] BYTE_USCORE = 8'h5F;
    localparam logic [7:0] BYTE_BSLASH = 8'h5C;
    localparam logic [7:0] BYTE_SLASH = 8'h2F;
    localparam logic [7:0] BYTE_STAR = 8'h2A;
    localparam logic [7:0] BYTE_DQUOTE = 8'h22;
    localparam logic [7:0] BYTE_SQUOTE = 8'h27;
    localparam logic [7:0] BYTE_HASH = 8'h23;

    // keyword text, first character in the low byte, zero padded
    function automatic logic [63:0] kw_text(input logic [4:0] idx);
        logic [63:0] t;
        unique case (idx)
            5'd0: t = {32'd0, "otua"};
            5'd1: t = {24'd0, "kaerb"};
            5'd2: t = {32'd0, "esac"};
            5'd3: t = {32'd0, "rahc"};
            5'd4: t = "eunitnoc";
            5'd5: t = {8'd0, "tluafed"};
            5'd6: t = {48'd0, "od"};
            5'd7: t = {16'd0, "elbuod"};
            5'd8: t = {32'd0, "esle"};
            5'd9: t = {24'd0, "yrtne"};
            5'd10: t = {32'd0, "mune"};
            5'd11: t = {16'd0, "nretxe"};
            5'd12: t = {24'd0, "taolf"};
            5'd13: t = {40'd0, "rof"};
            5'd14: t = {32'd0, "otog"};
            5'd15: t = {48'd0, "fi"};
            5'd16: t = {40'd0, "tni"};
            5'd17: t = {32'd0, "gnol"};
            5'd18: t = "retsiger";
            5'd19: t = {16'd0, "nruter"};
            5'd20: t = {24'd0, "trohs"};
            5'd21: t = {16'd0, "foezis"};
            5'd22: t = {16'd0, "citats"};
            5'd23: t = {16'd0, "tcurts"};
            5'd24: t = {16'd0, "hctiws"};
            5'd25: t = {8'd0, "fedepyt"};
            5'd26: t = {24'd0, "noinu"};
            5'd27: t = "dengisnu";
            5'd28: t = {32'd0, "diov"};
            5'd29: t = {24'd0, "elihw"};
            default: t = 64'd0;
        endcase
        return t;
    endfunction

    function automatic logic [3:0] kw_len(input logic [4:0] idx);
        logic [3:0] n;
        unique case (idx)
            5'd6, 5'd15: n = 4'd2;
            5'd13, 5'd16: n = 4'd3;
            5'd0, 5'd2, 5'd3, 5'd8, 5'd10, 5'd14, 5'd17, 5'd28: n = 4'd4;
            5'd1, 5'd9, 5'd12, 5'd20, 5'd26, 5'd29: n = 4'd5;
            5'd7, 5'd11, 5'd19, 5'd21, 5'd22, 5'd23, 5'd24: n = 4'd6;
            5'd5, 5'd25: n = 4'd7;
            5'd4, 5'd18, 5'd27: n = 4'd8;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

endpackage

// ===== rtl/cis_ram.sv =====
// generic single port write, single port read ram with registered read
module cis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/c_identifier_scanner_unit.sv =====
// identifier scanner top level: mode machine, keyword counter ram, identifier ram
//
// the scanner takes one beat per text byte or keyword-counter read and holds off
// s_axis_tready while it works on a beat. a byte inside a comment, a string, a
// character literal or a preprocessor line, or one more identifier character, is
// done on accept. a byte seen in normal mode, and the byte that ends a number or
// follows a lone slash, is accepted, then scanned as normal text in ST_END. a byte
// that ends an identifier is accepted, then compared with all keywords at once in
// ST_MATCH (its first eight characters are also held in a register copy for this).
// a keyword then updates its counter by read-modify-write in ST_KW_WRITE (the
// read is issued in ST_MATCH); any other identifier streams out of the identifier
// ram one character at a time, each by a ram read, then output. after either, the
// terminating byte is scanned as normal text in ST_END. a counter read issues its
// ram read on accept and is output from ST_KW_READ, and a "too long" answer is
// output from ST_ERR. output goes through a one-entry register, so a result beat
// waits only for m_axis_tready; while that register is full and not taken, every
// step that writes it waits too. the counter ram has no flip-flop per entry: after
// reset a clearing pass writes zero to its first KEYWORD_COUNT entries, during
// which s_axis_tready is low. byte 0xff ends the text, closes any pending
// identifier and then emits the line count (number of line feeds seen). an
// identifier longer than MAX_IDENT_LEN sets a sticky error; every later text byte
// then answers with one "too long" beat until reset.
module c_identifier_scanner_unit
    import cis_pkg::*;
#(
    parameter int MAX_IDENT_LEN = 32,
    parameter int KEYWORD_COUNT = 30,
    parameter int COUNTER_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // text_byte[7:0], keyword_index[12:8], zero fill
    input  logic        s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // id_char[7:0], line_number[23:8], count_value[39:24]
    output logic        m_axis_tlast,  // last_char
    output logic [2:0]  m_axis_tuser   // kind[1:0], call_flag[2]
);

`include "assert_macros.svh"

    localparam int IAW = $clog2(MAX_IDENT_LEN);
    localparam int LW  = $clog2(MAX_IDENT_LEN + 1);

    // front end state
    ctl_state_t        state_reg, state_next;
    scan_mode_t        mode_reg, mode_next;
    logic [15:0]       line_reg, line_next;
    logic [LW-1:0]     len_reg, len_next;
    logic              err_reg, err_next;
    logic              clr_reg, clr_next;
    logic [4:0]        kwi_reg, kwi_next;
    logic [7:0]        byte_reg, byte_next;
    logic              eot_reg, eot_next;
    logic              call_reg, call_next;
    logic [LW-1:0]     pos_reg, pos_next;
    // shadow of the first 8 identifier characters for keyword compare
    logic [63:0]       shadow_reg, shadow_next;
    logic [4:0]        hit_reg, hit_next;

    // output register
    logic        ov_reg, ov_next;
    logic [1:0]  okind_reg, okind_next;
    logic [7:0]  ochar_reg, ochar_next;
    logic        olast_reg, olast_next;
    logic [15:0] oline_reg, oline_next;
    logic        ocall_reg, ocall_next;
    logic [15:0] ocnt_reg, ocnt_next;

    // rams
    logic                    kw_we;
    logic [4:0]              kw_wa, kw_ra;
    logic [COUNTER_BITS-1:0] kw_wd, kw_rd;
    logic                    id_we;
    logic [IAW-1:0]          id_wa, id_ra;
    logic [7:0]              id_wd, id_rd;

    cis_ram #(.WIDTH(COUNTER_BITS), .DEPTH(KW_SLOTS)) u_kw_ram (
        .aclk(aclk), .wr_en(kw_we), .wr_addr(kw_wa), .wr_data(kw_wd),
        .rd_addr(kw_ra), .rd_data(kw_rd)
    );

    cis_ram #(.WIDTH(8), .DEPTH(MAX_IDENT_LEN)) u_id_ram (
        .aclk(aclk), .wr_en(id_we), .wr_addr(id_wa), .wr_data(id_wd),
        .rd_addr(id_ra), .rd_data(id_rd)
    );

    logic [7:0] in_byte;
    logic [4:0] in_idx;
    logic       in_fire, out_free;
    logic       ident_ch;
    logic [15:0] line_inc;

    assign in_byte  = s_axis_tdata[7:0];
    assign in_idx   = s_axis_tdata[12:8];
    assign out_free = !ov_reg || m_axis_tready;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign ident_ch = is_alpha(in_byte) || is_digit(in_byte) || in_byte == BYTE_USCORE;
    assign line_inc = (line_reg != 16'hFFFF) ? line_reg + 16'd1 : line_reg;

    // keyword compare over the shadow copy, combinational
    logic [4:0] cmp_idx;
    logic       cmp_ok;
    always_comb begin
        cmp_idx = 5'd0;
        cmp_ok  = 1'b0;
        for (int i = 0; i < KEYWORD_COUNT; i++) begin
            if (!cmp_ok && len_reg != '0 && {{(8 - LW > 0 ? 8 - LW : 0){1'b0}}, len_reg}
                    == {4'd0, kw_len(5'(i))} && shadow_reg == kw_text(5'(i))) begin
                cmp_ok  = 1'b1;
                cmp_idx = 5'(i);
            end
        end
    end

    always_comb begin
        state_next = state_reg; mode_next = mode_reg; line_next = line_reg;
        len_next = len_reg; err_next = err_reg; clr_next = clr_reg; kwi_next = kwi_reg;
        byte_next = byte_reg; eot_next = eot_reg; call_next = call_reg;
        pos_next = pos_reg; shadow_next = shadow_reg;
        hit_next = hit_reg;
        ov_next = ov_reg && !m_axis_tready;
        okind_next = okind_reg; ochar_next = ochar_reg; olast_next = olast_reg;
        oline_next = oline_reg; ocall_next = ocall_reg; ocnt_next = ocnt_reg;
        kw_we = 1'b0; kw_wa = kwi_reg; kw_wd = '0; kw_ra = kwi_reg;
        id_we = 1'b0; id_wa = pos_reg[IAW-1:0]; id_wd = in_byte; id_ra = pos_reg[IAW-1:0];
        s_axis_tready = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (clr_reg) begin
                    // clearing pass over the counter ram
                    kw_we = 1'b1; kw_wa = kwi_reg; kw_wd = '0;
                    kwi_next = kwi_reg + 5'd1;
                    if (kwi_reg == 5'(KEYWORD_COUNT - 1)) begin
                        clr_next = 1'b0;
                    end
                end else begin
                    s_axis_tready = out_free;
                end
                if (in_fire) begin
                    byte_next = in_byte;
                    if (s_axis_tuser) begin
                        kwi_next = in_idx; kw_ra = in_idx;
                        state_next = ST_KW_READ;
                    end else if (err_reg) begin
                        state_next = ST_ERR;
                    end else if (in_byte == BYTE_EOT) begin
                        eot_next = 1'b1; call_next = 1'b0;
                        state_next = (mode_reg == M_IDENT) ? ST_MATCH : ST_END;
                    end else if (mode_reg == M_IDENT) begin
                        if (ident_ch) begin
                            if (len_reg >= LW'(MAX_IDENT_LEN)) begin
                                err_next = 1'b1; state_next = ST_ERR;
                            end else begin
                                id_we = 1'b1; id_wa = len_reg[IAW-1:0];
                                if (len_reg < LW'(8)) begin
                                    shadow_next[len_reg[2:0]*8 +: 8] = in_byte;
                                end else begin
                                    shadow_next = '1;
                                end
                                len_next = len_reg + LW'(1);
                            end
                        end else begin
                            eot_next = 1'b0;
                            call_next = (in_byte == BYTE_PAREN);
                            state_next = ST_MATCH;
                        end
                    end else begin
                        unique case (mode_reg)
                            M_NUMBER: begin
                                if (!(is_alpha(in_byte) || is_digit(in_byte))) begin
                                    mode_next = M_NORMAL;
                                    state_next = ST_END; eot_next = 1'b0;
                                end
                            end
                            M_SLASH: begin
                                if (in_byte == BYTE_STAR) begin
                                    mode_next = M_COMMENT;
                                end else begin
                                    mode_next = M_NORMAL; state_next = ST_END;
                                    eot_next = 1'b0;
                                end
                            end
                            M_COMMENT: begin
                                if (in_byte == BYTE_LF) line_next = line_inc;
                                if (in_byte == BYTE_STAR) mode_next = M_COMMENT_STAR;
                            end
                            M_COMMENT_STAR: begin
                                if (in_byte == BYTE_LF) line_next = line_inc;
                                if (in_byte == BYTE_SLASH) mode_next = M_NORMAL;
                                else if (in_byte != BYTE_STAR) mode_next = M_COMMENT;
                            end
                            M_STRING: begin
                                if (in_byte == BYTE_LF) line_next = line_inc;
                                if (in_byte == BYTE_DQUOTE) mode_next = M_NORMAL;
                            end
                            M_CHAR_FIRST: begin
                                if (in_byte == BYTE_LF) line_next = line_inc;
                                mode_next = (in_byte == BYTE_BSLASH) ? M_CHAR_ESC
                                                                     : M_CHAR_CLOSE;
                            end
                            M_CHAR_ESC: begin
                                if (in_byte == BYTE_LF) line_next = line_inc;
                                mode_next = M_CHAR_CLOSE;
                            end
                            M_CHAR_CLOSE: begin
                                if (in_byte == BYTE_LF) line_next = line_inc;
                                mode_next = M_NORMAL;
                            end
                            M_PREPROC: begin
                                if (in_byte == BYTE_LF) begin
                                    line_next = line_inc; mode_next = M_NORMAL;
                                end else if (in_byte == BYTE_BSLASH) begin
                                    mode_next = M_PREPROC_CONT;
                                end
                            end
                            M_PREPROC_CONT: begin
                                if (in_byte == BYTE_LF) begin
                                    line_next = line_inc; mode_next = M_PREPROC;
                                end
                            end
                            default: begin
                                mode_next = M_NORMAL; state_next = ST_END;
                                eot_next = 1'b0;
                            end
                        endcase
                    end
                end
            end
            ST_KW_READ: begin
                if (out_free) begin
                    ov_next = 1'b1; okind_next = KIND_COUNT; ochar_next = '0;
                    olast_next = 1'b0; oline_next = '0; ocall_next = 1'b0;
                    ocnt_next = ({1'b0, kwi_reg} < 6'(KEYWORD_COUNT)) ? 16'(kw_rd)
                                                                        : 16'd0;
                    state_next = ST_IDLE;
                end
            end
            ST_MATCH: begin
                hit_next = cmp_idx;
                kw_ra = cmp_idx; kwi_next = cmp_idx;
                pos_next = '0; id_ra = '0;
                state_next = cmp_ok ? ST_KW_WRITE : ST_EMIT_RD;
            end
            ST_KW_WRITE: begin
                // counter read issued in match, saturating update here
                kw_we = 1'b1; kw_wa = hit_reg;
                kw_wd = (kw_rd != '1) ? kw_rd + COUNTER_BITS'(1) : kw_rd;
                len_next = '0; shadow_next = '0; mode_next = M_NORMAL;
                state_next = ST_END;
            end
            ST_EMIT_RD: begin
                id_ra = pos_reg[IAW-1:0];
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    ov_next = 1'b1; okind_next = KIND_CHAR; ochar_next = id_rd;
                    olast_next = (pos_reg + LW'(1) == len_reg);
                    oline_next = line_reg; ocall_next = call_reg; ocnt_next = '0;
                    pos_next = pos_reg + LW'(1);
                    id_ra = pos_next[IAW-1:0];
                    if (pos_reg + LW'(1) == len_reg) begin
                        len_next = '0; shadow_next = '0; mode_next = M_NORMAL;
                        state_next = ST_END;
                    end else begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_END: begin
                if (eot_reg) begin
                    if (out_free) begin
                        ov_next = 1'b1; okind_next = KIND_END; ochar_next = '0;
                        olast_next = 1'b0; oline_next = line_reg - 16'd1;
                        ocall_next = 1'b0; ocnt_next = '0;
                        mode_next = M_NORMAL; line_next = 16'd1; len_next = '0;
                        shadow_next = '0; eot_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end else begin
                    // the terminating byte is scanned as normal text
                    state_next = ST_IDLE;
                    mode_next = M_NORMAL;
                    if (byte_reg == BYTE_SLASH) mode_next = M_SLASH;
                    else if (byte_reg == BYTE_DQUOTE) mode_next = M_STRING;
                    else if (byte_reg == BYTE_SQUOTE) mode_next = M_CHAR_FIRST;
                    else if (byte_reg == BYTE_HASH) mode_next = M_PREPROC;
                    else if (is_digit(byte_reg)) mode_next = M_NUMBER;
                    else if (byte_reg == BYTE_LF) line_next = line_inc;
                    else if (is_alpha(byte_reg) || byte_reg == BYTE_USCORE) begin
                        id_we = 1'b1; id_wa = '0; id_wd = byte_reg;
                        shadow_next = {56'd0, byte_reg};
                        len_next = LW'(1); mode_next = M_IDENT;
                    end
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    ov_next = 1'b1; okind_next = KIND_TOO_LONG; ochar_next = '0;
                    olast_next = 1'b0; oline_next = line_reg; ocall_next = 1'b0;
                    ocnt_next = '0; state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE; mode_reg <= M_NORMAL; line_reg <= 16'd1;
            len_reg <= '0; err_reg <= 1'b0; clr_reg <= 1'b1; kwi_reg <= '0;
            eot_reg <= 1'b0; ov_reg <= 1'b0; shadow_reg <= '0;
        end else begin
            state_reg <= state_next; mode_reg <= mode_next; line_reg <= line_next;
            len_reg <= len_next; err_reg <= err_next; clr_reg <= clr_next;
            kwi_reg <= kwi_next; eot_reg <= eot_next; ov_reg <= ov_next;
            shadow_reg <= shadow_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next; call_reg <= call_next; pos_reg <= pos_next;
        hit_reg <= hit_next;
        okind_reg <= okind_next; ochar_reg <= ochar_next; olast_reg <= olast_next;
        oline_reg <= oline_next; ocall_reg <= ocall_next; ocnt_reg <= ocnt_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {ocnt_reg, oline_reg, ochar_reg};
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tuser  = {ocall_reg, okind_reg};

    `ASSERT_IMPL(a_no_in_during_clear, aclk, aresetn, clr_reg, !s_axis_tready)
    `ASSERT_IMPL(a_len_bound, aclk, aresetn, 1'b1, len_reg <= LW'(MAX_IDENT_LEN))
    `ASSERT_NEXT(a_err_sticky, aclk, aresetn, err_reg, err_reg)
    `ASSERT_IMPL(a_ready_idle, aclk, aresetn, s_axis_tready, state_reg == ST_IDLE)

endmodule

// ===== test/tb.sv =====
// self-checking testbench of the identifier scanner: c-like byte streams against a scoreboard
module tb
    import cis_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_LEN = 32;
    localparam int N_KW = 30;

    typedef struct {
        logic       req_type;
        logic [7:0] text_byte;
        logic [4:0] kw_index;
        logic       drain;     // sender waits here until every result has come
    } scan_item_t;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  id_char;
        logic        last_char;
        logic [15:0] line_number;
        logic        call_flag;
        logic [15:0] count_value;
    } scan_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [2:0]  m_axis_tuser;

    c_identifier_scanner_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock, 10 ns period
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    scan_item_t   pending_items[$];
    scan_result_t expected_results[$];
    int           errors;
    int           cycles;
    int           beats_in;
    int           hold_cycles;
    bit           hold_done;
    bit           send_busy;

    // shadow state of the scanner
    scan_mode_t   sh_mode;
    int           sh_line;
    logic [7:0]   sh_buf[MAX_LEN];
    int           sh_len;
    int           sh_kw_cnt[N_KW];
    bit           sh_sticky;

    string kw_words[N_KW] = '{"auto", "break", "case", "char", "continue", "default", "do",
        "double", "else", "entry", "enum", "extern", "float", "for", "goto", "if", "int",
        "long", "register", "return", "short", "sizeof", "static", "struct", "switch",
        "typedef", "union", "unsigned", "void", "while"};

    function automatic bit is_letter(logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function automatic bit is_num(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic void push_result(logic [1:0] kind, logic [7:0] ch, logic last,
                                        int line, logic call, int cnt);
        scan_result_t r;
        r.kind = kind;
        r.id_char = ch;
        r.last_char = last;
        r.line_number = line[15:0];
        r.call_flag = call;
        r.count_value = cnt[15:0];
        expected_results.push_back(r);
    endfunction

    function automatic void bump_line(logic [7:0] b);
        if (b == BYTE_LF && sh_line < 65535) sh_line++;
    endfunction

    // keyword hit bumps its counter, anything else goes out char by char
    function automatic void close_word(logic [7:0] follow);
        int hit;
        hit = -1;
        for (int i = 0; i < N_KW; i++) begin
            if (hit < 0 && kw_words[i].len() == sh_len && sh_len > 0) begin
                hit = i;
                for (int j = 0; j < sh_len; j++) begin
                    if (kw_words[i][j] != sh_buf[j]) hit = -1;
                end
            end
        end
        if (hit >= 0) begin
            if (sh_kw_cnt[hit] < 65535) sh_kw_cnt[hit]++;
        end else begin
            for (int i = 0; i < sh_len; i++) begin
                push_result(KIND_CHAR, sh_buf[i], i + 1 == sh_len, sh_line,
                            follow == BYTE_PAREN, 0);
            end
        end
        sh_len = 0;
        sh_mode = M_NORMAL;
    endfunction

    function automatic void scan_plain(logic [7:0] b);
        sh_mode = M_NORMAL;
        if (b == BYTE_SLASH) sh_mode = M_SLASH;
        else if (b == BYTE_DQUOTE) sh_mode = M_STRING;
        else if (b == BYTE_SQUOTE) sh_mode = M_CHAR_FIRST;
        else if (b == BYTE_HASH) sh_mode = M_PREPROC;
        else if (is_num(b)) sh_mode = M_NUMBER;
        else if (b == BYTE_LF) bump_line(b);
        else if (is_letter(b) || b == BYTE_USCORE) begin
            sh_buf[0] = b;
            sh_len = 1;
            sh_mode = M_IDENT;
        end
    endfunction

    function automatic void predict_scan(scan_item_t it);
        logic [7:0] b;
        b = it.text_byte;
        if (it.req_type) begin
            push_result(KIND_COUNT, 8'd0, 1'b0, 0, 1'b0,
                        (it.kw_index < N_KW) ? sh_kw_cnt[it.kw_index] : 0);
            return;
        end
        if (sh_sticky) begin
            push_result(KIND_TOO_LONG, 8'd0, 1'b0, sh_line, 1'b0, 0);
            return;
        end
        if (b == BYTE_EOT) begin
            if (sh_mode == M_IDENT) close_word(b);
            push_result(KIND_END, 8'd0, 1'b0, sh_line - 1, 1'b0, 0);
            sh_mode = M_NORMAL;
            sh_line = 1;
            sh_len = 0;
            return;
        end
        case (sh_mode)
            M_IDENT: begin
                if (is_letter(b) || is_num(b) || b == BYTE_USCORE) begin
                    if (sh_len >= MAX_LEN) begin
                        sh_sticky = 1'b1;
                        push_result(KIND_TOO_LONG, 8'd0, 1'b0, sh_line, 1'b0, 0);
                    end else begin
                        sh_buf[sh_len] = b;
                        sh_len++;
                    end
                end else begin
                    close_word(b);
                    scan_plain(b);
                end
            end
            M_NUMBER: if (!(is_letter(b) || is_num(b))) scan_plain(b);
            M_SLASH: begin
                if (b == BYTE_STAR) sh_mode = M_COMMENT;
                else scan_plain(b);
            end
            M_COMMENT: begin
                bump_line(b);
                if (b == BYTE_STAR) sh_mode = M_COMMENT_STAR;
            end
            M_COMMENT_STAR: begin
                bump_line(b);
                if (b == BYTE_SLASH) sh_mode = M_NORMAL;
                else if (b != BYTE_STAR) sh_mode = M_COMMENT;
            end
            M_STRING: begin
                bump_line(b);
                if (b == BYTE_DQUOTE) sh_mode = M_NORMAL;
            end
            M_CHAR_FIRST: begin
                bump_line(b);
                sh_mode = (b == BYTE_BSLASH) ? M_CHAR_ESC : M_CHAR_CLOSE;
            end
            M_CHAR_ESC: begin
                bump_line(b);
                sh_mode = M_CHAR_CLOSE;
            end
            M_CHAR_CLOSE: begin
                bump_line(b);
                sh_mode = M_NORMAL;
            end
            M_PREPROC: begin
                bump_line(b);
                if (b == BYTE_LF) sh_mode = M_NORMAL;
                else if (b == BYTE_BSLASH) sh_mode = M_PREPROC_CONT;
            end
            M_PREPROC_CONT: begin
                bump_line(b);
                if (b == BYTE_LF) sh_mode = M_PREPROC;
            end
            default: scan_plain(b);
        endcase
    endfunction

    // stimulus helpers
    function automatic void push_byte(logic [7:0] b);
        scan_item_t it;
        it.req_type = 1'b0;
        it.text_byte = b;
        it.kw_index = 5'($urandom);  // ignored on text beats
        it.drain = 1'b0;
        pending_items.push_back(it);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endfunction

    function automatic void push_kw_read(logic [4:0] idx);
        scan_item_t it;
        it.req_type = 1'b1;
        it.text_byte = 8'($urandom);  // ignored on counter reads
        it.kw_index = idx;
        it.drain = 1'b0;
        pending_items.push_back(it);
    endfunction

    function automatic void push_drain();
        scan_item_t it;
        it = '{1'b0, 8'd0, 5'd0, 1'b1};
        pending_items.push_back(it);
    endfunction

    function automatic logic [7:0] word_char(bit first);
        int r;
        r = $urandom_range(0, first ? 52 : 62);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        if (r == 52) return BYTE_USCORE;
        return 8'("0" + r - 53);
    endfunction

    // one random token, mostly well-formed c, sometimes noise
    function automatic void push_token();
        int n;
        case ($urandom_range(0, 19))
            0, 1, 2, 3: begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 32) : $urandom_range(1, 8);
                push_byte(word_char(1));
                for (int i = 1; i < n; i++) push_byte(word_char(0));
                push_byte(($urandom_range(0, 2) == 0) ? BYTE_PAREN : " ");
            end
            4, 5: begin
                push_text(kw_words[$urandom_range(0, N_KW - 1)]);
                push_byte(($urandom_range(0, 3) == 0) ? BYTE_PAREN : " ");
            end
            6: push_byte(BYTE_LF);
            7: push_text(" \t;");
            8: begin
                push_text("/*");
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++) push_byte(($urandom_range(0, 2) == 0) ? "*" : "a");
                if ($urandom_range(0, 2) == 0) push_byte(BYTE_LF);
                push_text("*/");
            end
            9: begin
                push_byte(BYTE_DQUOTE);
                n = $urandom_range(0, 5);
                for (int i = 0; i < n; i++) push_byte(word_char(0));
                if ($urandom_range(0, 3) == 0) push_byte(BYTE_LF);
                push_byte(BYTE_DQUOTE);
            end
            10: begin
                push_byte(BYTE_SQUOTE);
                if ($urandom_range(0, 1)) push_byte(BYTE_BSLASH);
                push_byte(word_char(0));
                push_byte(BYTE_SQUOTE);
            end
            11: begin
                push_text("#define x ");
                if ($urandom_range(0, 1)) push_text("\\\n y");
                push_byte(BYTE_LF);
            end
            12: begin
                push_byte(8'("0" + $urandom_range(0, 9)));
                n = $urandom_range(0, 4);
                for (int i = 0; i < n; i++) push_byte(word_char(0));
                push_byte(($urandom_range(0, 1)) ? "+" : " ");
            end
            13, 14: push_kw_read(5'($urandom));
            15: push_byte(($urandom_range(0, 3) == 0) ? BYTE_EOT : 8'($urandom));
            16: push_text("a/b");
            default: push_byte(8'($urandom));
        endcase
    endfunction

    // driver: takes beats at the rising edge, changes inputs at the falling edge
    int   send_gap;
    bit   sent_now;
    bit   calm_phase;
    scan_item_t cur_item;

    always @(posedge aclk) begin
        sent_now = 1'b0;
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            sent_now = 1'b1;
            beats_in++;
            predict_scan(cur_item);
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            send_gap = 0;
        end else if (!s_axis_tvalid || sent_now) begin
            if (send_gap > 0 && hold_cycles == 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
                send_busy = 1'b1;
            end else if (pending_items.size() > 0 && pending_items[0].drain) begin
                s_axis_tvalid <= 1'b0;
                if (expected_results.size() == 0) void'(pending_items.pop_front());
            end else if (pending_items.size() > 0) begin
                cur_item = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= cur_item.req_type;
                s_axis_tdata <= {3'd0, cur_item.kw_index, cur_item.text_byte};
                send_busy = 1'b1;
                if ($urandom_range(0, 63) == 0) calm_phase = !calm_phase;
                if (!calm_phase) begin
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3: send_gap = $urandom_range(1, 3);
                        4: send_gap = $urandom_range(10, 40);
                        default: send_gap = 0;
                    endcase
                end
            end else begin
                s_axis_tvalid <= 1'b0;
                send_busy = 1'b0;
            end
        end
    end

    // monitor: result beats checked against the oldest expectation
    int  recv_gap;
    scan_result_t got;
    scan_result_t want;

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.id_char = m_axis_tdata[7:0];
            got.line_number = m_axis_tdata[23:8];
            got.count_value = m_axis_tdata[39:24];
            got.kind = m_axis_tuser[1:0];
            got.call_flag = m_axis_tuser[2];
            got.last_char = m_axis_tlast;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat kind %0d data %h", $time, got.kind,
                         m_axis_tdata);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got != want) begin
                    $display("%0t: expected kind %0d char %h last %b line %0d call %b cnt %0d",
                             $time, want.kind, want.id_char, want.last_char,
                             want.line_number, want.call_flag, want.count_value);
                    $display("%0t: actual   kind %0d char %h last %b line %0d call %b cnt %0d",
                             $time, got.kind, got.id_char, got.last_char,
                             got.line_number, got.call_flag, got.count_value);
                    errors++;
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            recv_gap = 0;
        end else if (!hold_done && beats_in >= 150) begin
            // long back-pressure so the scanner fills up and stalls its input
            hold_done = 1'b1;
            hold_cycles = 400;
            m_axis_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles--;
            m_axis_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!calm_phase) begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3: recv_gap = $urandom_range(1, 3);
                    4: recv_gap = $urandom_range(10, 40);
                    default: recv_gap = 0;
                endcase
            end
        end
    end

    // run guard
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        errors = 0;
        cycles = 0;
        beats_in = 0;
        hold_cycles = 0;
        hold_done = 1'b0;
        send_busy = 1'b0;
        calm_phase = 1'b0;
        sh_mode = M_NORMAL;
        sh_line = 1;
        sh_len = 0;
        sh_sticky = 1'b0;
        foreach (sh_kw_cnt[i]) sh_kw_cnt[i] = 0;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 16'd0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;

        // directed: call, keyword, comment, empty string, escaped char, preproc, number
        push_text("int f(x)/**/\"\"'\\n'#a\\\n\n1ab ");
        push_kw_read(5'd16);
        push_kw_read(5'd0);
        push_kw_read(5'd31);  // beyond the table answers zero
        push_text("_Z9(");
        push_byte(BYTE_EOT);
        push_drain();

        // random c-like text
        while (pending_items.size() < 400) begin
            push_token();
            if ($urandom_range(0, 99) == 0) push_drain();
        end
        push_drain();
        push_text("w while(");
        push_byte(BYTE_EOT);
        push_drain();
        for (int i = 0; i < N_KW; i++) push_kw_read(5'(i));
        push_drain();

        // identifier one char too long, then the error stays set
        for (int i = 0; i <= MAX_LEN; i++) push_byte(word_char(i == 0));
        push_text("a(");
        push_byte(BYTE_EOT);
        push_kw_read(5'd15);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        wait (pending_items.size() == 0 && !send_busy && !s_axis_tvalid
              && expected_results.size() == 0);
        repeat (100) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
